/* rtl/tint_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tint_pkg
// Shared constants, codes and controller/datapath interface types for the
// transaction intent table.
// ----------------------------------------------------------------------------
package tint_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int MODE_W   = 3;
  localparam int TXN_W    = 64;
  localparam int KIND_W   = 16;
  localparam int PHASE_W  = 2;
  localparam int STATUS_W = 2;
  localparam int AFF_W    = 11;
  localparam int ENTRY_W  = TXN_W + PHASE_W;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 16;

  // Operation codes.
  localparam logic [MODE_W-1:0] MODE_CREATE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_APPLY  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_COMMIT = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REPLAY = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

  // Lifecycle phases of a stored intent.
  localparam logic [PHASE_W-1:0] PH_PENDING   = 2'd0;
  localparam logic [PHASE_W-1:0] PH_APPLIED   = 2'd1;
  localparam logic [PHASE_W-1:0] PH_COMMITTED = 2'd2;
  localparam logic [PHASE_W-1:0] PH_REPLAYED  = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic load;    // capture the incoming operation and reset the scan
    logic scan;    // walk the stored entries
    logic finish;  // commit the result and the new entry count
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;  // every stored entry has been processed
    logic out_free;   // the output register can take a result
  } dp_status_t;

endpackage

/* rtl/tint_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tint_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module tint_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/tint_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tint_ctrl
// Operation sequencer: accepts an operation, runs the entry scan and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module tint_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  tint_pkg::dp_status_t sts,
  output tint_pkg::dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_RESP = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/tint_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tint_dp
// Datapath: operation registers, entry store, scan pointers, hit counter,
// entry count and output register.
// ----------------------------------------------------------------------------
module tint_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [tint_pkg::IN_TDATA_W-1:0]      s_tdata,
  input  tint_pkg::dp_cmd_t                    cmd,
  output tint_pkg::dp_status_t                 sts,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [tint_pkg::OUT_TDATA_W-1:0]     m_tdata
);

  logic [tint_pkg::MODE_W-1:0]   mode;
  logic [tint_pkg::TXN_W-1:0]    txn;
  logic [tint_pkg::KIND_W-1:0]   kind;
  logic [tint_pkg::CNT_W-1:0]    count;
  logic [tint_pkg::CNT_W-1:0]    rd_idx;
  logic [tint_pkg::CNT_W-1:0]    wptr;
  logic [tint_pkg::CNT_W-1:0]    hits;
  logic [tint_pkg::ADDR_W-1:0]   pidx;
  logic                          pend;
  logic                          out_valid;
  logic [tint_pkg::STATUS_W-1:0] out_status;
  logic [tint_pkg::AFF_W-1:0]    out_aff;

  logic                          is_scan;
  logic                          rd_more;
  logic                          proc;
  logic                          hit;
  logic                          keep;
  logic                          we;
  logic [tint_pkg::ADDR_W-1:0]   waddr;
  logic [tint_pkg::ENTRY_W-1:0]  wdata;
  logic [tint_pkg::ENTRY_W-1:0]  rdata;
  logic [tint_pkg::TXN_W-1:0]    r_txn;
  logic [tint_pkg::PHASE_W-1:0]  r_phase;
  logic                          r_match;
  logic [tint_pkg::STATUS_W-1:0] res_status;
  logic                          create_ok;

  assign is_scan = mode inside {tint_pkg::MODE_APPLY, tint_pkg::MODE_COMMIT,
                                tint_pkg::MODE_REPLAY, tint_pkg::MODE_CLEAR};
  assign rd_more = is_scan && (rd_idx != count);
  assign proc    = cmd.scan && pend;

  assign r_txn   = rdata[tint_pkg::TXN_W-1:0];
  assign r_phase = rdata[tint_pkg::ENTRY_W-1:tint_pkg::TXN_W];
  assign r_match = (r_txn == txn);

  // Create is checked for bad arguments first, then for a full table.
  always_comb begin
    create_ok  = 1'b0;
    res_status = tint_pkg::ST_OK;
    case (mode)
      tint_pkg::MODE_CREATE: begin
        if (kind == '0 || txn == '0) begin
          res_status = tint_pkg::ST_INVALID;
        end else if (count >= tint_pkg::CNT_W'(tint_pkg::CAPACITY)) begin
          res_status = tint_pkg::ST_FULL;
        end else begin
          create_ok = 1'b1;
        end
      end
      tint_pkg::MODE_APPLY, tint_pkg::MODE_COMMIT, tint_pkg::MODE_REPLAY,
      tint_pkg::MODE_CLEAR: begin
        res_status = tint_pkg::ST_OK;
      end
      default: begin
        res_status = tint_pkg::ST_INVALID;
      end
    endcase
  end

  // Per-entry decision in the scan, one entry a cycle, and create's write.
  always_comb begin
    hit   = 1'b0;
    keep  = 1'b0;
    we    = 1'b0;
    waddr = pidx;
    wdata = rdata;
    if (cmd.finish && create_ok) begin
      we    = 1'b1;
      waddr = count[tint_pkg::ADDR_W-1:0];
      wdata = {tint_pkg::PH_PENDING, txn};
    end else if (proc) begin
      case (mode)
        tint_pkg::MODE_APPLY: begin
          if (r_match && r_phase == tint_pkg::PH_PENDING) begin
            hit   = 1'b1;
            we    = 1'b1;
            wdata = {tint_pkg::PH_APPLIED, r_txn};
          end
        end
        tint_pkg::MODE_COMMIT: begin
          if (r_match) begin
            we    = 1'b1;
            wdata = {tint_pkg::PH_COMMITTED, r_txn};
          end
        end
        tint_pkg::MODE_REPLAY: begin
          // The table is emptied afterwards, so the new phase is never read.
          hit = (r_phase != tint_pkg::PH_COMMITTED);
        end
        tint_pkg::MODE_CLEAR: begin
          if (r_match && r_phase == tint_pkg::PH_COMMITTED) begin
            hit = 1'b1;
          end else begin
            keep  = 1'b1;
            we    = 1'b1;
            waddr = wptr[tint_pkg::ADDR_W-1:0];
          end
        end
        default: begin
          hit = 1'b0;
        end
      endcase
    end
  end

  tint_ram #(
    .WIDTH (tint_pkg::ENTRY_W),
    .DEPTH (tint_pkg::CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_idx[tint_pkg::ADDR_W-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode <= s_tdata[2:0];
      txn  <= s_tdata[66:3];
      kind <= s_tdata[82:67];
    end
    if (cmd.load) begin
      rd_idx <= '0;
      wptr   <= '0;
      hits   <= '0;
    end else if (cmd.scan) begin
      if (rd_more) begin
        rd_idx <= rd_idx + 1'b1;
        pidx   <= rd_idx[tint_pkg::ADDR_W-1:0];
      end
      if (hit) begin
        hits <= hits + 1'b1;
      end
      if (keep) begin
        wptr <= wptr + 1'b1;
      end
    end
    if (cmd.finish) begin
      out_status <= res_status;
      out_aff    <= tint_pkg::AFF_W'(hits);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        pend <= 1'b0;
      end else if (cmd.scan) begin
        pend <= rd_more;
      end
      if (cmd.finish) begin
        if (create_ok) begin
          count <= count + 1'b1;
        end else if (mode == tint_pkg::MODE_REPLAY) begin
          count <= '0;
        end else if (mode == tint_pkg::MODE_CLEAR) begin
          count <= wptr;
        end
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.scan_done = !pend && !rd_more;
  assign sts.out_free  = !out_valid || m_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(tint_pkg::OUT_TDATA_W - tint_pkg::STATUS_W - tint_pkg::AFF_W){1'b0}},
                     out_aff, out_status};

endmodule

/* rtl/transaction_intent_table.sv */
`timescale 1ns / 1ps
// Create, commands on an empty table and unknown modes read no stored entries;
// apply, commit, replay and clear scan all n stored entries (up to 1024), one
// entry a cycle through the single read port of the entry store.
// Throughput: one operation at a time; the next is accepted once the result is in
// the output register. Reset empties the table; no clearing pass is needed.
// ----------------------------------------------------------------------------
// transaction_intent_table
// Ordered table of transaction intents with create, apply, commit, replay and
// clear operations, built as a sequencer and a scanning datapath.
// ----------------------------------------------------------------------------
module transaction_intent_table (
  input  logic        clk,
  input  logic        rst,
  // Operation stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,   // mode [2:0], txn_id [66:3], intent_type [82:67]
  // Result stream, one transfer per operation.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // status [1:0], affected [12:2]
);

  // The sequencer and the datapath talk only through these two bundles.
  tint_pkg::dp_cmd_t    cmd;
  tint_pkg::dp_status_t sts;

  // The sequencer accepts a transfer only when idle; it then steps the scan
  // until every stored entry has been seen and waits for the output register
  // to be free before it commits the result.
  tint_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the entries in one RAM word each (phase above id).
  // Clear compacts the table in place: kept entries are written back at a
  // trailing write pointer, which never overtakes the read pointer.
  tint_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

/* sim/intent_table_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// intent_table_checker
// Watches both streams of the transaction intent table, keeps its own copy of
// the table to work out the result of every accepted operation, and compares
// each result transfer with the oldest outcome still awaited.
// ----------------------------------------------------------------------------
module intent_table_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [87:0] s_tdata,   // mode [2:0], txn_id [66:3], intent_type [82:67]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // status [1:0], affected [12:2]
  output int          fails,
  output int          outstanding
);

  // Laid out as on the result bus: status in the low bits, affected above.
  typedef struct packed {
    logic [tint_pkg::AFF_W-1:0]    affected;
    logic [tint_pkg::STATUS_W-1:0] status;
  } outcome_t;

  // Shadow copy of the intent table.
  logic [tint_pkg::TXN_W-1:0]   shadow_txn   [tint_pkg::CAPACITY];
  logic [tint_pkg::PHASE_W-1:0] shadow_phase [tint_pkg::CAPACITY];
  int unsigned                  shadow_count;

  outcome_t awaited_q[$];

  // Applies one operation to the shadow table and returns what the block
  // should answer.
  function automatic outcome_t run_operation(logic [tint_pkg::MODE_W-1:0] mode,
                                             logic [tint_pkg::TXN_W-1:0] txn,
                                             logic [tint_pkg::KIND_W-1:0] kind);
    outcome_t    res;
    int unsigned hits;
    int unsigned keep;
    hits = 0;
    keep = 0;
    res.status = tint_pkg::ST_OK;
    case (mode)
      tint_pkg::MODE_CREATE: begin
        if (kind == '0 || txn == '0) begin
          res.status = tint_pkg::ST_INVALID;
        end else if (shadow_count >= tint_pkg::CAPACITY) begin
          res.status = tint_pkg::ST_FULL;
        end else begin
          shadow_txn[shadow_count]   = txn;
          shadow_phase[shadow_count] = tint_pkg::PH_PENDING;
          shadow_count++;
        end
      end
      tint_pkg::MODE_APPLY: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_txn[i] == txn && shadow_phase[i] == tint_pkg::PH_PENDING) begin
            shadow_phase[i] = tint_pkg::PH_APPLIED;
            hits++;
          end
        end
      end
      tint_pkg::MODE_COMMIT: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_txn[i] == txn) shadow_phase[i] = tint_pkg::PH_COMMITTED;
        end
      end
      tint_pkg::MODE_REPLAY: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_phase[i] != tint_pkg::PH_COMMITTED) begin
            shadow_phase[i] = tint_pkg::PH_REPLAYED;
            hits++;
          end
        end
        shadow_count = 0;
      end
      tint_pkg::MODE_CLEAR: begin
        // Committed intents of this id drop out; the rest close up in order.
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_txn[i] == txn && shadow_phase[i] == tint_pkg::PH_COMMITTED) begin
            hits++;
          end else begin
            shadow_txn[keep]   = shadow_txn[i];
            shadow_phase[keep] = shadow_phase[i];
            keep++;
          end
        end
        shadow_count = keep;
      end
      default: res.status = tint_pkg::ST_INVALID;
    endcase
    res.affected = hits[tint_pkg::AFF_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    int       errs;
    errs = 0;
    if (rst) begin
      shadow_count = 0;
      awaited_q.delete();
      fails <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[12:0];
        if (awaited_q.size() == 0) begin
          $display("%0t: stray result, expected nothing, got status %0d affected %0d",
                   $time, got.status, got.affected);
          errs++;
        end else begin
          want = awaited_q.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, got.status);
            errs++;
          end
          if (got.affected !== want.affected) begin
            $display("%0t: affected mismatch, expected %0d, got %0d",
                     $time, want.affected, got.affected);
            errs++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        awaited_q.push_back(run_operation(s_tdata[2:0], s_tdata[66:3], s_tdata[82:67]));
      end
      fails <= fails + errs;
    end
    outstanding <= awaited_q.size();
  end

endmodule

/* sim/tb_transaction_intent_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_transaction_intent_table
// Drives create, apply, commit, replay and clear operations into the intent
// table: a directed opening, a long random run over a small pool of ids with
// idling on both sides, a receiver hold-off and a sender pause, and a short
// closing run on a fresh id. A separate checker predicts and compares every
// result; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_transaction_intent_table;

  localparam int RANDOM_OPS  = 545;
  localparam int HOLD_CYCLES = 300;
  // Longest legal quiet spell is a full-table scan plus the hold-off, so this
  // leaves a wide margin.
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_WAIT  = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [87:0] s_tdata = '0;    // mode [2:0], txn_id [66:3], intent_type [82:67]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;         // status [1:0], affected [12:2]

  int fails;
  int outstanding;

  // Steering of the idling on either side, set by the stimulus process.
  logic tx_steady = 1'b0;
  logic rx_steady = 1'b0;
  int   holds_asked = 0;

  logic [tint_pkg::TXN_W-1:0] id_pool [4];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  transaction_intent_table i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  intent_table_checker i_chk (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .fails       (fails),
    .outstanding (outstanding)
  );

  // Result side. Normally tready is drawn at random and is high most of the time,
  // or stays high while rx_steady is set; when a hold-off is asked for, tready is
  // held low, so the result register fills and the block has to refuse further transfers.
  initial begin : result_sink
    int holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        holds_done++;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        m_tready <= rx_steady ? 1'b1 : ($urandom_range(99) >= 19);
      end
    end
  end

  // Watchdog: counts cycles in which neither stream completes a transfer.
  always @(posedge clk) begin
    int quiet;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet == STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Offers one operation and returns at the edge where the transfer happens.
  // tvalid is only lowered when a gap is taken, so back-to-back operations
  // never see it dropped and raised in the same step.
  task automatic offer_op(logic [tint_pkg::MODE_W-1:0] mode,
                          logic [tint_pkg::TXN_W-1:0] txn,
                          logic [tint_pkg::KIND_W-1:0] kind);
    while (!tx_steady && $urandom_range(99) < 19) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata  <= {5'b0, kind, txn, mode};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  // Ids of a few shapes, so that high bits, single bits and the all-ones value with one
  // bit cleared turn up as well as plain random ones. Never zero.
  function automatic logic [tint_pkg::TXN_W-1:0] fresh_id();
    logic [tint_pkg::TXN_W-1:0] v;
    case ($urandom_range(3))
      0:       v = {$urandom, $urandom};
      1:       v = tint_pkg::TXN_W'($urandom_range(1, 255));
      2:       v = {tint_pkg::TXN_W{1'b1}} ^
                   (tint_pkg::TXN_W'(1) << $urandom_range(tint_pkg::TXN_W - 1));
      default: v = tint_pkg::TXN_W'(1) << $urandom_range(tint_pkg::TXN_W - 1);
    endcase
    return (v == '0) ? tint_pkg::TXN_W'(1) : v;
  endfunction

  function automatic logic [tint_pkg::KIND_W-1:0] any_kind();
    return tint_pkg::KIND_W'($urandom_range(1, 65535));
  endfunction

  // One random operation. Most traffic is creates followed by apply, commit
  // and clear on the same few ids so that entries move through every phase;
  // the remainder is invalid creates, unknown ids, zero ids, replays and bad modes.
  task automatic random_op();
    int                         pick;
    logic [tint_pkg::TXN_W-1:0] txn;
    pick = $urandom_range(99);
    txn  = id_pool[$urandom_range(3)];
    if (pick < 40) begin
      offer_op(tint_pkg::MODE_CREATE, txn, any_kind());
    end else if (pick < 44) begin
      // Invalid create: zero kind, zero id or both.
      case ($urandom_range(2))
        0:       offer_op(tint_pkg::MODE_CREATE, txn, '0);
        1:       offer_op(tint_pkg::MODE_CREATE, '0, any_kind());
        default: offer_op(tint_pkg::MODE_CREATE, '0, '0);
      endcase
    end else if (pick < 58) begin
      offer_op(tint_pkg::MODE_APPLY, txn, tint_pkg::KIND_W'($urandom));
    end else if (pick < 70) begin
      offer_op(tint_pkg::MODE_COMMIT, txn, tint_pkg::KIND_W'($urandom));
    end else if (pick < 82) begin
      offer_op(tint_pkg::MODE_CLEAR, txn, tint_pkg::KIND_W'($urandom));
    end else if (pick < 87) begin
      // Commands aimed at an id that is absent, or at id zero.
      txn = $urandom_range(1) ? '0 : {$urandom, $urandom};
      case ($urandom_range(2))
        0:       offer_op(tint_pkg::MODE_APPLY, txn, tint_pkg::KIND_W'($urandom));
        1:       offer_op(tint_pkg::MODE_COMMIT, txn, tint_pkg::KIND_W'($urandom));
        default: offer_op(tint_pkg::MODE_CLEAR, txn, tint_pkg::KIND_W'($urandom));
      endcase
    end else if (pick < 93) begin
      offer_op(tint_pkg::MODE_REPLAY, {$urandom, $urandom}, tint_pkg::KIND_W'($urandom));
    end else begin
      // Codes above the clear operation are not defined.
      offer_op(tint_pkg::MODE_W'($urandom_range(tint_pkg::MODE_CLEAR + 1, 7)),
               {$urandom, $urandom}, tint_pkg::KIND_W'($urandom));
    end
  endtask

  initial begin : stimulus
    logic [tint_pkg::TXN_W-1:0] tail_id;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening: empty-table commands, invalid creates, the field
    // extremes, the phase walk of one id, clear keeping the order of the rest,
    // the undefined modes and replay with and without committed entries.
    offer_op(tint_pkg::MODE_APPLY,  {tint_pkg::TXN_W{1'b1}}, '0);
    offer_op(tint_pkg::MODE_CREATE, {tint_pkg::TXN_W{1'b1}}, '0);
    offer_op(tint_pkg::MODE_CREATE, '0, tint_pkg::KIND_W'(1));
    offer_op(tint_pkg::MODE_CREATE, '0, '0);
    offer_op(tint_pkg::MODE_CREATE, {tint_pkg::TXN_W{1'b1}}, {tint_pkg::KIND_W{1'b1}});
    offer_op(tint_pkg::MODE_CREATE, tint_pkg::TXN_W'(1), tint_pkg::KIND_W'(16'h8000));
    offer_op(tint_pkg::MODE_CREATE, {tint_pkg::TXN_W{1'b1}}, tint_pkg::KIND_W'(1));
    offer_op(tint_pkg::MODE_APPLY,  {tint_pkg::TXN_W{1'b1}}, '0);
    offer_op(tint_pkg::MODE_APPLY,  {tint_pkg::TXN_W{1'b1}}, '0);
    offer_op(tint_pkg::MODE_COMMIT, tint_pkg::TXN_W'(1), '0);
    offer_op(tint_pkg::MODE_APPLY,  '0, '0);
    offer_op(tint_pkg::MODE_COMMIT, '0, '0);
    offer_op(tint_pkg::MODE_CLEAR,  '0, '0);
    offer_op(tint_pkg::MODE_CLEAR,  {tint_pkg::TXN_W{1'b1}}, '0);
    offer_op(tint_pkg::MODE_COMMIT, {tint_pkg::TXN_W{1'b1}}, '0);
    offer_op(tint_pkg::MODE_CLEAR,  {tint_pkg::TXN_W{1'b1}}, '0);
    offer_op(tint_pkg::MODE_CLEAR,  tint_pkg::TXN_W'(1), '0);
    offer_op(3'd5, {tint_pkg::TXN_W{1'b1}}, {tint_pkg::KIND_W{1'b1}});
    offer_op(3'd6, '0, '0);
    offer_op(3'd7, tint_pkg::TXN_W'(64'h8000_0000_0000_0000), tint_pkg::KIND_W'(1));
    offer_op(tint_pkg::MODE_CREATE, tint_pkg::TXN_W'(64'h8000_0000_0000_0000),
             tint_pkg::KIND_W'(2));
    offer_op(tint_pkg::MODE_CREATE, tint_pkg::TXN_W'(2), tint_pkg::KIND_W'(4));
    offer_op(tint_pkg::MODE_COMMIT, tint_pkg::TXN_W'(2), '0);
    offer_op(tint_pkg::MODE_REPLAY, '0, '0);
    offer_op(tint_pkg::MODE_REPLAY, {tint_pkg::TXN_W{1'b1}}, {tint_pkg::KIND_W{1'b1}});

    // Random run. The id pool is renewed now and then so that ids of every
    // shape pass through the table.
    foreach (id_pool[k]) id_pool[k] = fresh_id();
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if ($urandom_range(29) == 0) id_pool[$urandom_range(3)] = fresh_id();
      // A long stretch in which neither side idles.
      if (n == 150) begin
        tx_steady = 1'b1;
        rx_steady = 1'b1;
      end
      // Receiver holds off while the sender keeps offering back to back.
      if (n == 300) begin
        rx_steady = 1'b0;
        holds_asked++;
      end
      if (n == 340) tx_steady = 1'b0;
      // Sender stops until every outstanding result has come back. The
      // count is looked at only once it includes the last transfer.
      if (n == 450) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        @(posedge clk);
      end
      random_op();
    end

    // Closing run on a fresh id: two creates, the invalid checks, an apply, a
    // commit of an absent id, a replay that counts the uncommitted entries, then
    // a create, commit and clear on the table that replay emptied.
    tail_id = fresh_id();
    offer_op(tint_pkg::MODE_CREATE, tail_id, any_kind());
    offer_op(tint_pkg::MODE_CREATE, tail_id, any_kind());
    offer_op(tint_pkg::MODE_CREATE, tail_id, '0);
    offer_op(tint_pkg::MODE_CREATE, '0, any_kind());
    offer_op(tint_pkg::MODE_APPLY,  tail_id, '0);
    offer_op(tint_pkg::MODE_COMMIT, ~tail_id, '0);
    offer_op(tint_pkg::MODE_REPLAY, tail_id, '0);
    offer_op(tint_pkg::MODE_CREATE, tail_id, any_kind());
    offer_op(tint_pkg::MODE_COMMIT, tail_id, '0);
    offer_op(tint_pkg::MODE_CLEAR,  tail_id, '0);
    s_tvalid <= 1'b0;

    // Drain, then give the block time to show any stray transfer.
    @(posedge clk);
    wait (outstanding == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* transaction_intent_table.f */
rtl/tint_pkg.sv
rtl/tint_ram.sv
rtl/tint_ctrl.sv
rtl/tint_dp.sv
rtl/transaction_intent_table.sv
sim/intent_table_checker.sv
sim/tb_transaction_intent_table.sv
